// File: design/gn3o_pkg.sv
// gn3o_pkg: shared constants for the 3D octave gradient noise block.
// Holds configuration register indexes, widths and output saturation limits.
// No dependencies.
package gn3o_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 1'b1;

	localparam int SEED_W   = 8;
	localparam int OCTCFG_W = 4;

	// Permutation table
	localparam int PERM_DEPTH = 256;
	localparam int PERM_W     = 8;
	localparam int HASH_W     = 4;
	localparam int GRAD_CNT   = 8;

	// Coordinate fields and integer lattice part
	localparam int COORD_IN_W = 24;
	localparam int LATTICE_W  = 8;

	// Fade polynomial coefficients: 10 + 6*t2 - 15*t
	localparam int FADE_C10 = 10;
	localparam int FADE_C6  = 6;
	localparam int FADE_C15 = 15;

	// Output format: signed Q2.14, saturated
	localparam int OUT_W    = 16;
	localparam int OUT_FRAC = 14;
	localparam int SAT_POS  = 32767;
	localparam int SAT_NEG  = 32768;
	localparam logic [OUT_W-1:0] OUT_POS_MAX = 16'h7fff;
	localparam logic [OUT_W-1:0] OUT_NEG_MIN = 16'h8000;

endpackage

// File: design/gradient_noise_3d_octaves_top.sv
// gradient_noise_3d_octaves_top: 3D improved gradient noise summed over octaves.
// One shared multiplier under a sequencer, a 256 x 8 permutation memory and a
// shift-subtract normalizing divider. Depends on gn3o_pkg.
//
//   channel   dir  handshake              payload
//   in        in   in_valid / in_ready    coord_x, coord_y, coord_z (Q8.F)
//   out       out  out_valid / out_ready  noise_value (signed Q2.14)
//   cfg       in   cfg_we                 cfg_index, cfg_data
//
// Each octave runs 15 lookup and fade steps, one gradient step, seven lerps
// on the multiplier and one accumulate; setup, the bit-serial normalizing
// divide and hand-off follow the last octave.
// After reset and after every seed write the table is rebuilt: all 256
// entries are filled, then 256 swaps of four phases each are made;
// in_ready stays low meanwhile.
// A finished result waits in the output register; the next item is taken
// while it waits.
module gradient_noise_3d_octaves_top #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gn3o_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gn3o_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [gn3o_pkg::COORD_IN_W-1:0]      coord_x,
	input  logic [gn3o_pkg::COORD_IN_W-1:0]      coord_y,
	input  logic [gn3o_pkg::COORD_IN_W-1:0]      coord_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [gn3o_pkg::OUT_W-1:0]    noise_value
);
	import gn3o_pkg::*;

	localparam int F       = FRAC_BITS;
	localparam int COORD_W = LATTICE_W + F;
	localparam int GW      = F + 3;
	localparam int DWD     = GW + 1;
	localparam int QW      = F + 5;
	localparam int MA_W    = F + 2;
	localparam int MB_W    = F + 6;
	localparam int P_W     = MA_W + MB_W;
	localparam int ACC_W   = F + 3 + MAX_OCTAVES;
	localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
	localparam int NUM_SH  = (F < OUT_FRAC) ? (OUT_FRAC - F) : 0;
	localparam int DEN_SH  = (F > OUT_FRAC) ? (F - OUT_FRAC) : 0;
	localparam int QUO_W   = ACC_W + NUM_SH;
	localparam int DIV_W   = MAX_OCTAVES + DEN_SH;
	localparam int DCNT_W  = $clog2(QUO_W + 1);
	localparam int QX_W    = QUO_W + OUT_W + 1;
	localparam int PIDX_W  = $clog2(PERM_DEPTH);

	// Sequencer states
	localparam logic [3:0] ST_FILL = 4'd0;
	localparam logic [3:0] ST_SWAP = 4'd1;
	localparam logic [3:0] ST_IDLE = 4'd2;
	localparam logic [3:0] ST_LOOK = 4'd3;
	localparam logic [3:0] ST_GRAD = 4'd4;
	localparam logic [3:0] ST_LERP = 4'd5;
	localparam logic [3:0] ST_ACC  = 4'd6;
	localparam logic [3:0] ST_PREP = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	localparam logic [3:0] STEP_LAST = 4'd14;
	localparam logic [2:0] LERP_LAST = 3'd6;

	// Swap phases of the table rebuild
	localparam logic [1:0] SW_RD_I  = 2'd0;
	localparam logic [1:0] SW_RD_J  = 2'd1;
	localparam logic [1:0] SW_WR_I  = 2'd2;
	localparam logic [1:0] SW_WR_J  = 2'd3;

	// Fade phases per axis
	localparam logic [2:0] FD_SQ    = 3'd0;
	localparam logic [2:0] FD_CUBE  = 3'd1;
	localparam logic [2:0] FD_POLY  = 3'd2;
	localparam logic [2:0] FD_MUL   = 3'd3;
	localparam logic [2:0] FD_STORE = 3'd4;

	logic [3:0]               state_q;
	logic [SEED_W-1:0]        seed_q;
	logic [OCTCFG_W-1:0]      octave_count_q;
	logic [PIDX_W-1:0]        cnt_q;
	logic [1:0]               sph_q;
	logic [PERM_W-1:0]        ti_q;

	logic [PERM_W-1:0]        perm_mem [PERM_DEPTH];
	logic [PERM_W-1:0]        rdata_q;
	logic                     mem_we;
	logic [PIDX_W-1:0]        mem_wa;
	logic [PERM_W-1:0]        mem_wd;
	logic [PIDX_W-1:0]        mem_ra;

	logic [COORD_W-1:0]       cx_q, cy_q, cz_q;
	logic [OCT_W-1:0]         n_q, oct_q;
	logic [3:0]               step_q;
	logic [PERM_W-1:0]        px0_q, px1_q, pa_q, pa1_q, pb_q, pb1_q;
	logic [HASH_W-1:0]        h_q [GRAD_CNT];

	logic [F-1:0]             t2_q, t3_q;
	logic [QW-1:0]            q_q;
	logic [F:0]               fade_val_q [3];

	logic signed [GW-1:0]     g_q [GRAD_CNT];
	logic signed [GW-1:0]     m_q [7];
	logic signed [DWD-1:0]    d_q;
	logic [2:0]               li_q;
	logic [1:0]               lph_q;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [P_W-1:0]    p_q;

	logic signed [ACC_W-1:0]  acc_q;
	logic                     neg_q;
	logic [QUO_W-1:0]         quo_q;
	logic [DIV_W-1:0]         rem_q;
	logic [DIV_W-1:0]         dvs_q;
	logic [DCNT_W-1:0]        div_cnt_q;

	logic                     out_valid_q;
	logic [OUT_W-1:0]         noise_q;

	// Derived combinational values
	logic [PIDX_W-1:0]        swap_j;
	logic [LATTICE_W-1:0]     lat_x, lat_y, lat_z;
	logic [1:0]               fax;
	logic [2:0]               fph;
	logic [F-1:0]             ft;
	logic [QW-1:0]            q_calc;
	logic signed [GW-1:0]     fxs, fys, fzs, fxm, fym, fzm;
	logic [F:0]               lt;
	logic signed [GW-1:0]     la, lb;
	logic signed [P_W-1:0]    p_adj, sd_full;
	logic signed [ACC_W-1:0]  acc_next;
	logic [OCT_W-1:0]         n_clamp;
	logic [DIV_W-1:0]         ones;
	logic [DIV_W:0]           rs;
	logic [QX_W-1:0]          qx;
	logic [OUT_W-1:0]         sat_val;
	logic [COORD_W+COORD_IN_W-1:0] ext_x, ext_y, ext_z;

	function automatic logic signed [GW-1:0] grad_f(
		input logic [HASH_W-1:0]  h,
		input logic signed [GW-1:0] x,
		input logic signed [GW-1:0] y,
		input logic signed [GW-1:0] z
	);
		logic signed [GW-1:0] u;
		logic signed [GW-1:0] v;
		u = (h < 4'd8) ? x : y;
		v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		if (h[0]) begin
			u = -u;
		end
		if (h[1]) begin
			v = -v;
		end
		return u + v;
	endfunction

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign noise_value = noise_q;

	// Decode lattice, fractions and step fields
	always_comb begin
		swap_j = seed_q + cnt_q;
		lat_x  = cx_q[F +: LATTICE_W];
		lat_y  = cy_q[F +: LATTICE_W];
		lat_z  = cz_q[F +: LATTICE_W];
		fxs    = GW'(cx_q[F-1:0]);
		fys    = GW'(cy_q[F-1:0]);
		fzs    = GW'(cz_q[F-1:0]);
		fxm    = fxs - GW'(1 << F);
		fym    = fys - GW'(1 << F);
		fzm    = fzs - GW'(1 << F);
		if (step_q < 4'd5) begin
			fax = 2'd0;
			fph = step_q[2:0];
		end else if (step_q < 4'd10) begin
			fax = 2'd1;
			fph = 3'(step_q - 4'd5);
		end else begin
			fax = 2'd2;
			fph = 3'(step_q - 4'd10);
		end
		case (fax)
			2'd0:    ft = cx_q[F-1:0];
			2'd1:    ft = cy_q[F-1:0];
			default: ft = cz_q[F-1:0];
		endcase
		q_calc = (QW'(FADE_C10) << F) + QW'(t2_q) * QW'(FADE_C6) - QW'(ft) * QW'(FADE_C15);
	end

	// Select lerp operands
	always_comb begin
		case (li_q)
			3'd0: begin la = g_q[0]; lb = g_q[1]; lt = fade_val_q[0]; end
			3'd1: begin la = g_q[2]; lb = g_q[3]; lt = fade_val_q[0]; end
			3'd2: begin la = g_q[4]; lb = g_q[5]; lt = fade_val_q[0]; end
			3'd3: begin la = g_q[6]; lb = g_q[7]; lt = fade_val_q[0]; end
			3'd4: begin la = m_q[0]; lb = m_q[1]; lt = fade_val_q[1]; end
			3'd5: begin la = m_q[2]; lb = m_q[3]; lt = fade_val_q[1]; end
			default: begin la = m_q[4]; lb = m_q[5]; lt = fade_val_q[2]; end
		endcase
		p_adj   = p_q + (p_q[P_W-1] ? P_W'((1 << F) - 1) : P_W'(0));
		sd_full = p_adj >>> F;
	end

	// Drive the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_LOOK) begin
			case (fph)
				FD_SQ: begin
					mul_a = MA_W'(ft);
					mul_b = MB_W'(ft);
				end
				FD_CUBE: begin
					mul_a = MA_W'(p_q[F +: F]);
					mul_b = MB_W'(ft);
				end
				FD_MUL: begin
					mul_a = MA_W'(t3_q);
					mul_b = MB_W'(q_q);
				end
				default: begin
					mul_a = '0;
				end
			endcase
		end else if (state_q == ST_LERP && lph_q == 2'd1) begin
			mul_a = MA_W'(lt);
			mul_b = MB_W'(d_q);
		end
	end

	// Octave sum, normalization and saturation
	always_comb begin
		acc_next = (acc_q <<< 1) + ACC_W'(m_q[6]);
		if (octave_count_q == '0) begin
			n_clamp = OCT_W'(1);
		end else if (int'(octave_count_q) > MAX_OCTAVES) begin
			n_clamp = OCT_W'(MAX_OCTAVES);
		end else begin
			n_clamp = OCT_W'(octave_count_q);
		end
		ones = (DIV_W'(1) << n_q) - DIV_W'(1);
		rs   = {rem_q, quo_q[QUO_W-1]};
		qx   = QX_W'(quo_q);
		if (neg_q) begin
			sat_val = (qx > QX_W'(SAT_NEG)) ? OUT_NEG_MIN : OUT_W'(0) - quo_q[OUT_W-1:0];
		end else begin
			sat_val = (qx > QX_W'(SAT_POS)) ? OUT_POS_MAX : quo_q[OUT_W-1:0];
		end
		ext_x = {COORD_W'(0), coord_x};
		ext_y = {COORD_W'(0), coord_y};
		ext_z = {COORD_W'(0), coord_z};
	end

	// Permutation memory control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q;
		mem_wd = cnt_q;
		mem_ra = '0;
		unique case (state_q)
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_SWAP: begin
				case (sph_q)
					SW_RD_I: mem_ra = cnt_q;
					SW_RD_J: mem_ra = swap_j;
					SW_WR_I: begin
						mem_we = 1'b1;
						mem_wd = rdata_q;
					end
					default: begin
						mem_we = 1'b1;
						mem_wa = swap_j;
						mem_wd = ti_q;
					end
				endcase
			end
			ST_LOOK: begin
				case (step_q)
					4'd0:    mem_ra = lat_x;
					4'd1:    mem_ra = lat_x + 8'd1;
					4'd2:    mem_ra = px0_q + lat_y;
					4'd3:    mem_ra = px0_q + lat_y + 8'd1;
					4'd4:    mem_ra = px1_q + lat_y;
					4'd5:    mem_ra = px1_q + lat_y + 8'd1;
					4'd6:    mem_ra = pa_q + lat_z;
					4'd7:    mem_ra = pa_q + lat_z + 8'd1;
					4'd8:    mem_ra = pb_q + lat_z;
					4'd9:    mem_ra = pb_q + lat_z + 8'd1;
					4'd10:   mem_ra = pa1_q + lat_z;
					4'd11:   mem_ra = pa1_q + lat_z + 8'd1;
					4'd12:   mem_ra = pb1_q + lat_z;
					4'd13:   mem_ra = pb1_q + lat_z + 8'd1;
					default: mem_ra = '0;
				endcase
			end
			default: begin
				mem_ra = '0;
			end
		endcase
	end

	// Permutation memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			perm_mem[mem_wa] <= mem_wd;
		end
		rdata_q <= perm_mem[mem_ra];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (state_q == ST_SWAP && sph_q == SW_RD_J) begin
			ti_q <= rdata_q;
		end
		if (state_q == ST_IDLE && in_valid) begin
			cx_q  <= ext_x[COORD_W-1:0];
			cy_q  <= ext_y[COORD_W-1:0];
			cz_q  <= ext_z[COORD_W-1:0];
			n_q   <= n_clamp;
			acc_q <= '0;
		end
		if (state_q == ST_LOOK) begin
			// capture lookup results
			case (step_q)
				4'd1:  px0_q <= rdata_q;
				4'd2:  px1_q <= rdata_q;
				4'd3:  pa_q  <= rdata_q;
				4'd4:  pa1_q <= rdata_q;
				4'd5:  pb_q  <= rdata_q;
				4'd6:  pb1_q <= rdata_q;
				4'd7:  h_q[0] <= rdata_q[HASH_W-1:0];
				4'd8:  h_q[4] <= rdata_q[HASH_W-1:0];
				4'd9:  h_q[1] <= rdata_q[HASH_W-1:0];
				4'd10: h_q[5] <= rdata_q[HASH_W-1:0];
				4'd11: h_q[2] <= rdata_q[HASH_W-1:0];
				4'd12: h_q[6] <= rdata_q[HASH_W-1:0];
				4'd13: h_q[3] <= rdata_q[HASH_W-1:0];
				4'd14: h_q[7] <= rdata_q[HASH_W-1:0];
				default: begin
				end
			endcase
			// fade polynomial of the current axis
			case (fph)
				FD_CUBE:  t2_q <= p_q[F +: F];
				FD_POLY: begin
					t3_q <= p_q[F +: F];
					q_q  <= q_calc;
				end
				FD_STORE: fade_val_q[fax] <= p_q[F +: F+1];
				default: begin
				end
			endcase
		end
		if (state_q == ST_GRAD) begin
			for (int i = 0; i < GRAD_CNT; i++) begin
				g_q[i] <= grad_f(h_q[i], i[0] ? fxm : fxs, i[1] ? fym : fys,
					i[2] ? fzm : fzs);
			end
		end
		if (state_q == ST_LERP) begin
			if (lph_q == 2'd0) begin
				d_q <= DWD'(lb) - DWD'(la);
			end
			if (lph_q == 2'd2) begin
				m_q[li_q] <= la + GW'(sd_full);
			end
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_next;
			cx_q  <= {cx_q[COORD_W-2:0], 1'b0};
			cy_q  <= {cy_q[COORD_W-2:0], 1'b0};
			cz_q  <= {cz_q[COORD_W-2:0], 1'b0};
		end
		if (state_q == ST_PREP) begin
			neg_q <= acc_q[ACC_W-1];
			quo_q <= QUO_W'(acc_q[ACC_W-1] ? -acc_q : acc_q) << NUM_SH;
			rem_q <= '0;
			dvs_q <= ones << DEN_SH;
		end
		if (state_q == ST_DIV) begin
			// one quotient bit per cycle
			if (rs >= {1'b0, dvs_q}) begin
				rem_q <= DIV_W'(rs - {1'b0, dvs_q});
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rs[DIV_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			noise_q <= sat_val;
		end
	end

	// Sequencer and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_FILL;
			seed_q         <= '0;
			octave_count_q <= OCTCFG_W'(1);
			cnt_q          <= '0;
			sph_q          <= SW_RD_I;
			step_q         <= '0;
			oct_q          <= '0;
			li_q           <= '0;
			lph_q          <= '0;
			div_cnt_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			// raise the output transaction when a result is handed off, drop it once taken
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && cfg_index == CFG_SEED) begin
				// a seed write restarts the table rebuild
				seed_q  <= cfg_data[SEED_W-1:0];
				state_q <= ST_FILL;
				cnt_q   <= '0;
				sph_q   <= SW_RD_I;
			end else begin
				unique case (state_q)
					ST_FILL: begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == PIDX_W'(PERM_DEPTH - 1)) begin
							state_q <= ST_SWAP;
							sph_q   <= SW_RD_I;
						end
					end
					ST_SWAP: begin
						sph_q <= sph_q + 1'b1;
						if (sph_q == SW_WR_J) begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == PIDX_W'(PERM_DEPTH - 1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
					ST_IDLE: begin
						if (in_valid) begin
							state_q <= ST_LOOK;
							step_q  <= '0;
							oct_q   <= '0;
						end
					end
					ST_LOOK: begin
						step_q <= step_q + 1'b1;
						if (step_q == STEP_LAST) begin
							state_q <= ST_GRAD;
						end
					end
					ST_GRAD: begin
						state_q <= ST_LERP;
						li_q    <= '0;
						lph_q   <= '0;
					end
					ST_LERP: begin
						if (lph_q == 2'd2) begin
							lph_q <= '0;
							li_q  <= li_q + 1'b1;
							if (li_q == LERP_LAST) begin
								state_q <= ST_ACC;
							end
						end else begin
							lph_q <= lph_q + 1'b1;
						end
					end
					ST_ACC: begin
						if (oct_q == OCT_W'(n_q - 1'b1)) begin
							state_q <= ST_PREP;
						end else begin
							oct_q   <= oct_q + 1'b1;
							step_q  <= '0;
							state_q <= ST_LOOK;
						end
					end
					ST_PREP: begin
						state_q   <= ST_DIV;
						div_cnt_q <= '0;
					end
					ST_DIV: begin
						div_cnt_q <= div_cnt_q + 1'b1;
						if (div_cnt_q == DCNT_W'(QUO_W - 1)) begin
							state_q <= ST_DONE;
						end
					end
					ST_DONE: begin
						// hold until the output register is free
						if (!out_valid_q || out_ready) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
			if (cfg_we && cfg_index == CFG_OCTAVES) begin
				octave_count_q <= cfg_data[OCTCFG_W-1:0];
			end
		end
	end

	// Checks
	a_take_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !cfg_we |=> !in_ready)
		else $error("in_ready stayed high after an input transaction");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

	a_octave_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> oct_q < n_q)
		else $error("octave index beyond octave count");

	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !$past(cfg_we) |-> $past(state_q) == ST_DIV ||
		$past(state_q) == ST_DONE)
		else $error("result stage entered without a finished divide");

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for gradient_noise_3d_octaves_top.
// Predicts each noise value with its own octave noise model and checks the results in order.
// Depends on gn3o_pkg and the design files.
`timescale 1ns / 1ps

module tb_top;
	import gn3o_pkg::*;

	typedef struct packed {
		logic [COORD_IN_W-1:0] x;
		logic [COORD_IN_W-1:0] y;
		logic [COORD_IN_W-1:0] z;
	} point_t;

	localparam int FB = 16;
	localparam longint ONE = 64'sd1 <<< FB;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SEED;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COORD_IN_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] noise_value;

	gradient_noise_3d_octaves_top DUT (.*);

	always #6 clk = ~clk;

	// Predictor state
	logic [7:0] perm [256];
	logic [3:0] octaves_cfg;
	logic signed [OUT_W-1:0] expected_noise [$];
	point_t pending_points [$];
	int errors = 0;
	int send_idle_pct = 33, recv_idle_pct = 74;
	int hold_off_cycles = 0;
	bit stim_done = 0;

	function automatic void shuffle_perm(input logic [7:0] s);
		logic [7:0] tmp;
		int j;
		for (int i = 0; i < 256; i++) perm[i] = i[7:0];
		for (int i = 0; i < 256; i++) begin
			j = (s + i) & 255;
			tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
		end
	endfunction

	function automatic logic [7:0] lookup(input int idx);
		return perm[idx & 255];
	endfunction

	function automatic longint fade(input longint t);
		longint t2, t3, q;
		t2 = (t * t) >>> FB;
		t3 = (t2 * t) >>> FB;
		q = (64'sd10 <<< FB) + 6 * t2 - 15 * t;
		return (t3 * q) >>> FB;
	endfunction

	function automatic longint lerp(input longint t, input longint a, input longint b);
		longint p;
		p = t * (b - a);
		return (p < 0) ? a - ((-p) >>> FB) : a + (p >>> FB);
	endfunction

	function automatic longint grad(input logic [7:0] hash, input longint x, input longint y,
			input longint z);
		logic [3:0] h;
		longint u, v;
		h = hash[3:0];
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic longint lattice_noise(input logic [23:0] cx, input logic [23:0] cy,
			input logic [23:0] cz);
		int xi, yi, zi, a, aa, ab, b, ba, bb;
		longint x, y, z, u, v, w, lo, hi;
		xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
		x = cx[15:0]; y = cy[15:0]; z = cz[15:0];
		u = fade(x); v = fade(y); w = fade(z);
		a = lookup(xi) + yi; aa = lookup(a) + zi; ab = lookup(a + 1) + zi;
		b = lookup(xi + 1) + yi; ba = lookup(b) + zi; bb = lookup(b + 1) + zi;
		lo = lerp(v, lerp(u, grad(lookup(aa), x, y, z), grad(lookup(ba), x - ONE, y, z)),
			lerp(u, grad(lookup(ab), x, y - ONE, z), grad(lookup(bb), x - ONE, y - ONE, z)));
		hi = lerp(v,
			lerp(u, grad(lookup(aa + 1), x, y, z - ONE),
				grad(lookup(ba + 1), x - ONE, y, z - ONE)),
			lerp(u, grad(lookup(ab + 1), x, y - ONE, z - ONE),
				grad(lookup(bb + 1), x - ONE, y - ONE, z - ONE)));
		return lerp(w, lo, hi);
	endfunction

	function automatic logic signed [OUT_W-1:0] octave_noise(input point_t p);
		int n;
		longint acc, num, den, r;
		n = octaves_cfg;
		if (n < 1) n = 1;
		if (n > 8) n = 8;
		acc = 0;
		for (int i = 0; i < n; i++)
			acc += lattice_noise(p.x << i, p.y << i, p.z << i) * (64'sd1 <<< (n - 1 - i));
		num = acc * (64'sd1 <<< OUT_FRAC);
		den = ((64'sd1 <<< n) - 1) * ONE;
		r = num / den;
		if (r > SAT_POS) r = SAT_POS;
		if (r < -SAT_NEG) r = -SAT_NEG;
		return r[OUT_W-1:0];
	endfunction

	// Driver: present queued points, predict on each accepted transaction
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_noise.push_back(octave_noise({coord_x, coord_y, coord_z}));
			void'(pending_points.pop_front());
		end
		if (!in_valid || in_ready) begin
			if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				coord_x <= pending_points[0].x;
				coord_y <= pending_points[0].y;
				coord_z <= pending_points[0].z;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result transaction, drive out_ready
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_noise.size() == 0) begin
				$error("unexpected noise_value %0d", noise_value);
				errors++;
			end else begin
				if (noise_value !== expected_noise[0]) begin
					$error("noise_value expected %0d actual %0d", expected_noise[0], noise_value);
					errors++;
				end
				void'(expected_noise.pop_front());
			end
		end
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SEED) shuffle_perm(val[7:0]);
		else octaves_cfg = val[3:0];
	endtask

	// Hold until every queued point is sent and every result has come back
	task automatic drain();
		while (pending_points.size() > 0 || in_valid || expected_noise.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(3))
			0: return 24'($urandom_range(24'hffffff));
			1: return {8'($urandom_range(255)), 16'h0000} | 24'($urandom_range(1));
			2: return {8'($urandom_range(255)), 16'hffff};
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic add_point(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
		point_t p;
		p.x = x; p.y = y; p.z = z;
		pending_points.push_back(p);
	endtask

	int seeds [6] = '{0, 255, 1, 0, 128, 77};
	int octs [6] = '{1, 8, 0, 15, 3, 5};

	initial begin
		octaves_cfg = 4'd1;
		shuffle_perm(8'd0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and lattice edges at reset configuration
		add_point(24'h000000, 24'h000000, 24'h000000);
		add_point(24'hffffff, 24'hffffff, 24'hffffff);
		add_point(24'h008000, 24'h008000, 24'h008000);
		add_point(24'hff0000, 24'h00ffff, 24'h800001);
		add_point(24'h010000, 24'hfe0000, 24'h7fffff);
		add_point(24'haaaaaa, 24'h555555, 24'hffffff);
		drain();
		write_reg(CFG_OCTAVES, 8);
		add_point(24'hffffff, 24'hffffff, 24'hffffff);
		add_point(24'h000001, 24'h800000, 24'h7fffff);
		add_point(24'h123456, 24'hfedcba, 24'h0f0f0f);
		drain();

		// Random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_SEED, seeds[ph]);
			write_reg(CFG_OCTAVES, octs[ph]);
			send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 74 : 0;
			recv_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 33 : 0;
			if (ph == 4) hold_off_cycles = 3000;
			for (int k = 0; k < 140; k++) add_point(rand_coord(), rand_coord(), rand_coord());
			drain();
		end

		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

// File: files.f
design/gn3o_pkg.sv
design/gradient_noise_3d_octaves_top.sv
tb/sv/tb_top.sv
